[hw/rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Field widths, operation and status codes, default sizes and the memory
// command struct used between the controller and the element store.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Fixed field widths of the request and result items.
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHOW_ALL   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Strobes from the controller to the element store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

[hw/rtl/deq_if.sv]
// ----------------------------------------------------------------------------
// deq_if: request and result channels of the double-ended queue
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface deq_req_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       status;
  logic                      last;

  modport source (output valid, output result_value, output status, output last,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last,
                  output ready);
endinterface

[hw/rtl/deq_mem.sv]
// ----------------------------------------------------------------------------
// deq_mem: element store of the double-ended queue
// Single-port-write, single-port-read synchronous RAM with a registered read.
// The read data register holds its value until the next read.
// ----------------------------------------------------------------------------
module deq_mem #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  deq_pkg::mem_cmd_t     cmd,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] store [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

[hw/rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl: controller of the double-ended queue
// Keeps the front index and element count, issues reads and writes to the
// element store, and owns the result register that faces the output channel.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  deq_req_if.sink               req,
  deq_rsp_if.source             rsp,
  output deq_pkg::mem_cmd_t     cmd,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic [AW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data
);
  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int KW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t                    state;
  logic [AW-1:0]             front;
  logic [CW-1:0]             count;
  logic [CW-1:0]             rem;
  logic [CW-1:0]             rd_off;
  logic                      ovalid;
  logic signed [VALUE_W-1:0] oval;
  logic [STATUS_W-1:0]       ostat;
  logic                      olast;

  logic          out_free;
  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          emit_go;
  logic          ovalid_next;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;

  // Position of an offset from the front, wrapped around the ring.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Handshake and occupancy.
  assign out_free  = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign emit_go   = (state == S_EMIT) && out_free;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = wrap_add(front, CW'(1));

  assign rsp.valid        = ovalid;
  assign rsp.result_value = oval;
  assign rsp.status       = ostat;
  assign rsp.last         = olast;

  // Store accesses. Reads and writes never fall in the same cycle, so no forwarding
  // is needed.
  always_comb begin
    cmd     = '0;
    wr_addr = front;
    rd_addr = front;
    wr_data = DATA_WIDTH'(req.value[KW-1:0]);
    if (accept) begin
      unique case (req.mode) inside
        MODE_PUSH_FRONT: begin
          cmd.wr_en = !is_full;
          wr_addr   = front_dec;
        end
        MODE_PUSH_BACK: begin
          cmd.wr_en = !is_full;
          wr_addr   = wrap_add(front, count);
        end
        MODE_POP_FRONT, MODE_SHOW_ALL: begin
          cmd.rd_en = !is_empty;
          rd_addr   = front;
        end
        MODE_POP_BACK: begin
          cmd.rd_en = !is_empty;
          rd_addr   = wrap_add(front, count - 1'b1);
        end
        default: begin
        end
      endcase
    end else if (emit_go && (rem != CW'(1))) begin
      cmd.rd_en = 1'b1;
      rd_addr   = wrap_add(front, rd_off);
    end
  end

  // The result register stays full until taken, and is loaded by a push, by
  // an empty report or by each emitted element.
  always_comb begin
    ovalid_next = ovalid && !rsp.ready;
    if (emit_go) begin
      ovalid_next = 1'b1;
    end else if (accept) begin
      case (req.mode) inside
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          ovalid_next = 1'b1;
        end
        MODE_POP_FRONT, MODE_POP_BACK, MODE_SHOW_ALL: begin
          ovalid_next = is_empty;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer, pointers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      front  <= '0;
      count  <= '0;
      rem    <= '0;
      rd_off <= '0;
      ovalid <= 1'b0;
    end else begin
      ovalid <= ovalid_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.mode) inside
              MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                oval   <= VALUE_W'(req.value[KW-1:0]);
                olast  <= 1'b1;
                if (is_full) begin
                  ostat <= ST_FULL;
                end else begin
                  ostat <= ST_OK;
                  count <= count + 1'b1;
                  if (req.mode == MODE_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              MODE_POP_FRONT, MODE_POP_BACK: begin
                if (is_empty) begin
                  oval   <= '0;
                  ostat  <= ST_EMPTY;
                  olast  <= 1'b1;
                end else begin
                  state <= S_EMIT;
                  rem   <= CW'(1);
                  count <= count - 1'b1;
                  if (req.mode == MODE_POP_FRONT) begin
                    front <= front_inc;
                  end
                end
              end
              MODE_SHOW_ALL: begin
                if (is_empty) begin
                  oval   <= '0;
                  ostat  <= ST_EMPTY;
                  olast  <= 1'b1;
                end else begin
                  state  <= S_EMIT;
                  rem    <= count;
                  rd_off <= CW'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EMIT: begin
          // The element read in the previous step moves to the result register.
          if (out_free) begin
            oval   <= VALUE_W'(rd_data[KW-1:0]);
            ostat  <= ST_OK;
            olast  <= (rem == CW'(1));
            if (rem == CW'(1)) begin
              state <= S_IDLE;
            end else begin
              rem    <= rem - 1'b1;
              rd_off <= rd_off + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/double_ended_queue.sv]
// A push, or a pop or display of an empty queue, shows its result in the cycle after
// the item is taken. Pushes are taken one per cycle while the result channel is ready.
// A pop or display moves each element through the store's read data register and the
// result register, one per cycle while the result channel is ready, and takes no new
// request until its last element is registered. Reset is synchronous: it empties the
// queue and the result register; the element store itself is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue on a ring buffer
// Push and pop at either end, and a front-to-back listing of all elements.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_cmd_t              cmd;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  // Pointer logic, sequencing and result register.
  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Element store.
  deq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[hw/rtl/deq_checker.sv]
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic [deq_pkg::MODE_W-1:0]         req_mode,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [deq_pkg::VALUE_W-1:0] rsp_result_value,
  input logic [deq_pkg::STATUS_W-1:0]       rsp_status,
  input logic                               rsp_last
);
  import deq_pkg::*;

  // A result that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result item withdrawn before it was taken");

  // Every push gets its single, final result in the next cycle.
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_PUSH_FRONT || req_mode == MODE_PUSH_BACK)
    |=> rsp_valid && rsp_last && (rsp_status == ST_OK || rsp_status == ST_FULL))
    else $error("push did not produce one final result");

  // An empty or full report is always the only result of its item.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_last)
    else $error("empty or full result not marked last");

  // An empty report carries a zero value.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_result_value == '0)
    else $error("empty result carries a nonzero value");

  // Reset leaves no result on offer.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered right after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_mode         (req.mode),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_value (rsp.result_value),
  .rsp_status       (rsp.status),
  .rsp_last         (rsp.last)
);
